### hw/rtl/m4i_pkg.sv
// Shared constants, command/status types and index tables for the 4x4 matrix inverter.
package m4i_pkg;

	localparam int DEF_FRAC_BITS  = 16;
	localparam int DEF_ELEM_WIDTH = 32;

	// Limbs of one element width that cover the widest product (determinant).
	localparam int LIMBS   = 5;
	localparam int LIMB_W  = 3;
	localparam int PERMS   = 6;
	localparam int PERM_W  = 3;

	typedef struct packed {
		logic              mem_we;
		logic [3:0]        mem_waddr;
		logic              el_rd;
		logic [3:0]        el_raddr;
		logic              p_load;
		logic              p_from_t;
		logic              p_from_cof;
		logic              mul_step;
		logic              mul_clr;
		logic [LIMB_W-1:0] limb;
		logic              acc_clr;
		logic              acc_add;
		logic              acc_neg;
		logic              cof_we;
		logic              cof_rd;
		logic [3:0]        cof_addr;
		logic              cof_neg;
		logic              det_clr;
		logic              det_add;
		logic              sing_eval;
		logic              div_init;
		logic              div_step;
		logic              out_load;
		logic [3:0]        out_idx;
	} m4i_cmd_t;

	typedef struct packed {
		logic singular;
	} m4i_status_t;

	// n-th index of 0..3 with index x left out.
	function automatic logic [1:0] skip_idx(input logic [1:0] n, input logic [1:0] x);
		return (n >= x) ? n + 2'd1 : n;
	endfunction

	// Column picked in row n of the 3x3 minor by permutation p.
	function automatic logic [1:0] perm_col(input logic [PERM_W-1:0] p, input logic [1:0] n);
		logic [5:0] cols;
		cols = 6'b10_01_00;
		unique case (p)
			3'd0: cols = 6'b10_01_00;
			3'd1: cols = 6'b01_10_00;
			3'd2: cols = 6'b10_00_01;
			3'd3: cols = 6'b00_10_01;
			3'd4: cols = 6'b01_00_10;
			3'd5: cols = 6'b00_01_10;
			default: cols = 6'b10_01_00;
		endcase
		return cols[n*2 +: 2];
	endfunction

	// Odd permutations subtract.
	function automatic logic perm_neg(input logic [PERM_W-1:0] p);
		return (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
	endfunction

endpackage

### hw/rtl/m4i_dp.sv
// Datapath: element store, limb-serial multiplier, cofactor store, divider, output registers.
module m4i_dp #(
	parameter int FRAC_BITS  = m4i_pkg::DEF_FRAC_BITS,
	parameter int ELEM_WIDTH = m4i_pkg::DEF_ELEM_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  m4i_pkg::m4i_cmd_t            cmd,
	output m4i_pkg::m4i_status_t         status,
	input  logic signed [ELEM_WIDTH-1:0] element_value,
	input  logic                         cfg_we,
	input  logic [30:0]                  cfg_wdata,
	output logic signed [ELEM_WIDTH-1:0] inverse_value,
	output logic [1:0]                   out_row,
	output logic [1:0]                   out_col,
	output logic                         singular,
	output logic                         last
);
	localparam int W    = ELEM_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int CW   = 3*W + 2;
	localparam int DW   = 4*W + 3;
	localparam int LW   = m4i_pkg::LIMBS * W;
	localparam int PW   = 2*W + 1;
	localparam int NUMW = CW + 2*F;
	localparam int RW   = ((NUMW > DW + W + 2) ? NUMW : DW + W + 2) + 1;
	localparam int TW   = (DW > 31 + 3*F) ? DW : 31 + 3*F;
	localparam int QW   = W + 1;
	localparam logic [W-1:0] ONE_Q = W'(1) << F;
	localparam logic [W-1:0] MAXP  = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] IDENT = (F < W - 1) ? ONE_Q : MAXP;

	logic [W-1:0]         el_mem [16];
	logic signed [W-1:0]  el_rd_q;
	logic signed [CW-1:0] cof_mem [16];
	logic signed [CW-1:0] cof_rd_q;

	logic [30:0]          thr_q;
	logic signed [DW-1:0] p_q;
	logic signed [LW-1:0] t_q;
	logic signed [PW-1:0] prod_q;
	logic [m4i_pkg::LIMB_W-1:0] k_q;
	logic                 prod_v_q;
	logic signed [CW-1:0] acc_q;
	logic signed [DW-1:0] det_q;
	logic                 sing_q;
	logic [RW-1:0]        rem_q;
	logic [RW-1:0]        dsh_q;
	logic [QW-1:0]        quo_q;
	logic                 ovf_q;
	logic                 neg_q;

	// limb-serial multiply operands, then cofactor sign, divider and rounding terms
	logic signed [LW-1:0] p_ext;
	logic [W-1:0]         limb;
	logic                 limb_top;
	logic [W:0]           mul_a;
	logic signed [PW-1:0] prod_c;
	logic signed [LW-1:0] prod_ext;
	logic signed [CW-1:0] cof_val;
	logic [DW-1:0]        dmag;
	logic [CW-1:0]        cmag;
	logic [RW-1:0]        num;
	logic                 ge;
	logic                 rnd;
	logic [W+1:0]         qr;
	logic [W+1:0]         lim;
	logic [W+1:0]         sat;
	logic [W-1:0]         res;

	assign p_ext    = {{(LW-DW){p_q[DW-1]}}, p_q};
	assign limb     = p_ext[cmd.limb*W +: W];
	assign limb_top = (cmd.limb == m4i_pkg::LIMB_W'(m4i_pkg::LIMBS - 1));
	assign mul_a    = {limb_top & limb[W-1], limb};
	assign prod_c   = $signed(mul_a) * el_rd_q;
	assign prod_ext = {{(LW-PW){prod_q[PW-1]}}, prod_q};
	assign cof_val  = cmd.cof_neg ? -acc_q : acc_q;
	assign dmag     = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
	assign cmag     = cof_rd_q[CW-1] ? CW'(-cof_rd_q) : CW'(cof_rd_q);
	assign num      = RW'(cmag) << (2*F);
	assign ge       = (rem_q >= dsh_q);
	assign rnd      = ({rem_q, 1'b0} >= (RW+1)'(dmag));
	assign qr       = (W+2)'(quo_q) + (W+2)'(rnd);
	assign lim      = ((W+2)'(1) << (W-1)) - (W+2)'(!neg_q);
	assign sat      = (ovf_q || (qr > lim)) ? lim : qr;
	assign res      = neg_q ? -sat[W-1:0] : sat[W-1:0];

	assign status.singular = sing_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			el_mem[cmd.mem_waddr] <= element_value;
		end
		if (cmd.el_rd) begin
			el_rd_q <= el_mem[cmd.el_raddr];
		end
		if (cmd.cof_we) begin
			cof_mem[cmd.cof_addr] <= cof_val;
		end
		if (cmd.cof_rd) begin
			cof_rd_q <= cof_mem[cmd.cof_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= 31'd1;
			prod_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			prod_v_q <= cmd.mul_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			prod_q <= prod_c;
			k_q    <= cmd.limb;
		end
		if (cmd.mul_clr) begin
			t_q <= '0;
		end else if (prod_v_q) begin
			t_q <= t_q + (prod_ext << (k_q * W));
		end
		if (cmd.p_load) begin
			p_q <= {{(DW-W){el_rd_q[W-1]}}, el_rd_q};
		end else if (cmd.p_from_t) begin
			p_q <= t_q[DW-1:0];
		end else if (cmd.p_from_cof) begin
			p_q <= {{(DW-CW){cof_val[CW-1]}}, cof_val};
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= cmd.acc_neg ? acc_q - p_q[CW-1:0] : acc_q + p_q[CW-1:0];
		end
		if (cmd.det_clr) begin
			det_q <= '0;
		end else if (cmd.det_add) begin
			det_q <= det_q + p_q;
		end
		if (cmd.sing_eval) begin
			sing_q <= (TW'(dmag) <= (TW'(thr_q) << (3*F)));
		end
		if (cmd.div_init) begin
			rem_q <= num;
			dsh_q <= RW'(dmag) << W;
			ovf_q <= (num >= (RW'(dmag) << (W+1)));
			neg_q <= cof_rd_q[CW-1] ^ det_q[DW-1];
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? rem_q - dsh_q : rem_q;
			quo_q <= {quo_q[QW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.out_load) begin
			if (sing_q) begin
				inverse_value <= (cmd.out_idx[3:2] == cmd.out_idx[1:0]) ? IDENT : '0;
			end else begin
				inverse_value <= res;
			end
			out_row  <= cmd.out_idx[3:2];
			out_col  <= cmd.out_idx[1:0];
			singular <= sing_q;
			last     <= (cmd.out_idx == 4'd15);
		end
	end

endmodule

### hw/rtl/m4i_ctrl.sv
// Controller: load counter, cofactor/determinant sequencer, divider and output sequencing.
module m4i_ctrl #(
	parameter int ELEM_WIDTH = m4i_pkg::DEF_ELEM_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output m4i_pkg::m4i_cmd_t    cmd,
	input  m4i_pkg::m4i_status_t status
);
	localparam int CNT_W = $clog2(ELEM_WIDTH + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_COF_START, S_T_RD1, S_T_LD1, S_T_RD3, S_MUL, S_MUL_END, S_MUL_FIN,
		S_T_ACC, S_COF_DONE, S_DET_ACC, S_COF_NEXT, S_SING, S_OUT_RD, S_DIV_INIT,
		S_DIV, S_OUT_WAIT
	} state_t;

	state_t                      state_q;
	state_t                      ret_q;
	logic [3:0]                  load_cnt_q;
	logic                        full_q;
	logic [3:0]                  cof_idx_q;
	logic [m4i_pkg::PERM_W-1:0]  perm_q;
	logic [m4i_pkg::LIMB_W-1:0]  limb_q;
	logic [CNT_W-1:0]            div_cnt_q;
	logic [3:0]                  out_idx_q;
	logic                        out_valid_q;
	logic                        busy;
	logic                        in_acc;
	logic                        out_take;
	logic [1:0]                  r;
	logic [1:0]                  c;

	assign r = cof_idx_q[3:2];
	assign c = cof_idx_q[1:0];
	assign busy = !((state_q == S_IDLE) || (state_q == S_OUT_RD) || (state_q == S_DIV_INIT)
		|| (state_q == S_DIV) || (state_q == S_OUT_WAIT));
	assign in_ready  = !full_q && !busy;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_take  = (state_q == S_OUT_WAIT) && (!out_valid_q || out_ready);

	always_comb begin
		cmd           = '0;
		cmd.mem_we    = in_acc;
		cmd.mem_waddr = load_cnt_q;
		cmd.limb      = limb_q;
		cmd.out_idx   = out_idx_q;
		unique case (state_q)
			S_COF_START: begin
				cmd.acc_clr = 1'b1;
				cmd.det_clr = (cof_idx_q == 4'd0);
			end
			S_T_RD1: begin
				cmd.el_rd    = 1'b1;
				cmd.el_raddr = {m4i_pkg::skip_idx(2'd0, r),
					m4i_pkg::skip_idx(m4i_pkg::perm_col(perm_q, 2'd0), c)};
			end
			S_T_LD1: begin
				cmd.p_load   = 1'b1;
				cmd.el_rd    = 1'b1;
				cmd.el_raddr = {m4i_pkg::skip_idx(2'd1, r),
					m4i_pkg::skip_idx(m4i_pkg::perm_col(perm_q, 2'd1), c)};
			end
			S_T_RD3: begin
				cmd.el_rd    = 1'b1;
				cmd.el_raddr = {m4i_pkg::skip_idx(2'd2, r),
					m4i_pkg::skip_idx(m4i_pkg::perm_col(perm_q, 2'd2), c)};
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				cmd.mul_clr  = (limb_q == '0);
			end
			S_MUL_FIN: cmd.p_from_t = 1'b1;
			S_T_ACC: begin
				cmd.acc_add = 1'b1;
				cmd.acc_neg = m4i_pkg::perm_neg(perm_q);
			end
			S_COF_DONE: begin
				cmd.cof_we     = 1'b1;
				cmd.cof_addr   = cof_idx_q;
				cmd.cof_neg    = r[0] ^ c[0];
				cmd.p_from_cof = (r == 2'd0);
				cmd.el_rd      = (r == 2'd0);
				cmd.el_raddr   = {2'd0, c};
			end
			S_DET_ACC:  cmd.det_add = 1'b1;
			S_SING:     cmd.sing_eval = 1'b1;
			S_OUT_RD: begin
				cmd.cof_rd   = 1'b1;
				cmd.cof_addr = {out_idx_q[1:0], out_idx_q[3:2]};
			end
			S_DIV_INIT: cmd.div_init = 1'b1;
			S_DIV:      cmd.div_step = 1'b1;
			S_OUT_WAIT: cmd.out_load = out_take;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			load_cnt_q  <= '0;
			full_q      <= 1'b0;
			cof_idx_q   <= '0;
			perm_q      <= '0;
			limb_q      <= '0;
			div_cnt_q   <= '0;
			out_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				load_cnt_q <= load_cnt_q + 4'd1;
				if (load_cnt_q == 4'd15) begin
					full_q <= 1'b1;
				end
			end
			if (out_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (full_q) begin
						cof_idx_q <= '0;
						state_q   <= S_COF_START;
					end
				end
				S_COF_START: begin
					perm_q  <= '0;
					state_q <= S_T_RD1;
				end
				S_T_RD1: state_q <= S_T_LD1;
				S_T_LD1: begin
					ret_q   <= S_T_RD3;
					state_q <= S_MUL;
				end
				S_T_RD3: begin
					ret_q   <= S_T_ACC;
					state_q <= S_MUL;
				end
				S_MUL: begin
					limb_q <= limb_q + 1'b1;
					if (limb_q == m4i_pkg::LIMB_W'(m4i_pkg::LIMBS - 1)) begin
						state_q <= S_MUL_END;
					end
				end
				S_MUL_END: state_q <= S_MUL_FIN;
				S_MUL_FIN: begin
					limb_q  <= '0;
					state_q <= ret_q;
				end
				S_T_ACC: begin
					perm_q <= perm_q + 1'b1;
					if (perm_q == m4i_pkg::PERM_W'(m4i_pkg::PERMS - 1)) begin
						state_q <= S_COF_DONE;
					end else begin
						state_q <= S_T_RD1;
					end
				end
				S_COF_DONE: begin
					if (r == 2'd0) begin
						ret_q   <= S_DET_ACC;
						state_q <= S_MUL;
					end else begin
						state_q <= S_COF_NEXT;
					end
				end
				S_DET_ACC: state_q <= S_COF_NEXT;
				S_COF_NEXT: begin
					cof_idx_q <= cof_idx_q + 4'd1;
					state_q   <= (cof_idx_q == 4'd15) ? S_SING : S_COF_START;
				end
				S_SING: begin
					full_q    <= 1'b0;
					out_idx_q <= '0;
					state_q   <= S_OUT_RD;
				end
				S_OUT_RD: state_q <= status.singular ? S_OUT_WAIT : S_DIV_INIT;
				S_DIV_INIT: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == CNT_W'(ELEM_WIDTH)) begin
						state_q <= S_OUT_WAIT;
					end
				end
				S_OUT_WAIT: begin
					if (out_take) begin
						out_idx_q <= out_idx_q + 4'd1;
						state_q   <= (out_idx_q == 4'd15) ? S_IDLE : S_OUT_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_start_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && $past(state_q == S_IDLE) && full_q |=> (state_q == S_COF_START))
		else $error("compute did not start on a full store");
	a_cof_after_perms: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COF_DONE) |-> $past(state_q == S_T_ACC)
			&& (perm_q == m4i_pkg::PERM_W'(m4i_pkg::PERMS)))
		else $error("cofactor written before all terms");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_cnt_q <= CNT_W'(ELEM_WIDTH)))
		else $error("divider ran past its step count");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && (out_idx_q == 4'd15) |=> (state_q == S_IDLE) && out_valid_q)
		else $error("run did not end after sixteenth item");

endmodule

### hw/rtl/matrix4_inverse_top.sv
// Top level of the 4x4 fixed-point matrix inverter (adjugate over determinant).
// Each cofactor sums 6 terms of two 5-limb multiplies; row-0 cofactors add one more multiply
//   into the determinant. Results start once all cofactors are done, each one from the
//   bit-serial divider, which a singular matrix skips. The next matrix loads while results
//   drain. Async reset clears the controller and sets the threshold to 1; both element and
//   cofactor stores stay undefined until written.
module matrix4_inverse_top #(
	parameter int FRAC_BITS  = m4i_pkg::DEF_FRAC_BITS,
	parameter int ELEM_WIDTH = m4i_pkg::DEF_ELEM_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [ELEM_WIDTH-1:0] element_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [ELEM_WIDTH-1:0] inverse_value,
	output logic [1:0]                   out_row,
	output logic [1:0]                   out_col,
	output logic                         singular,
	output logic                         last,
	input  logic                         cfg_we,
	input  logic [30:0]                  cfg_wdata
);
	// command and status between sequencer and datapath
	m4i_pkg::m4i_cmd_t    cmd;
	m4i_pkg::m4i_status_t status;

	m4i_ctrl #(
		.ELEM_WIDTH(ELEM_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	m4i_dp #(
		.FRAC_BITS (FRAC_BITS),
		.ELEM_WIDTH(ELEM_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.element_value (element_value),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.inverse_value (inverse_value),
		.out_row       (out_row),
		.out_col       (out_col),
		.singular      (singular),
		.last          (last)
	);

endmodule
